FILE: rtl/sliding_window_median_core_macros.svh
// Assertion macros for the checker of the median core
`ifndef SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define SWM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sliding window median check failed");

// Check that cons holds in the cycle after ante
`define SWM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sliding window median check failed");

`endif

FILE: rtl/swm_pkg.sv
package swm_pkg;

    // Built defaults
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Window length register
    localparam int         CFG_W     = 7;
    localparam logic [6:0] LEN_RESET = 7'd3;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic step;  // an item is accepted this cycle
        logic full;  // window full before this item, so one entry is evicted
    } swm_ctl_t;

    // Status one cell shows its neighbours
    typedef struct packed {
        logic valid; // cell holds a window entry
        logic gt;    // held value is above the incoming sample
    } swm_flag_t;

endpackage

FILE: rtl/swm_cell.sv
module swm_cell #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int IDX         = 0,
    localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic                          aclk,
    input  swm_pkg::swm_ctl_t             ctl,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic [AGE_W-1:0]              len_m1,
    input  logic [CNT_W-1:0]              fill,
    input  logic signed [SAMPLE_BITS-1:0] left_val,
    input  logic [AGE_W-1:0]              left_age,
    input  swm_pkg::swm_flag_t            left_flag,
    input  logic signed [SAMPLE_BITS-1:0] right_val,
    input  logic [AGE_W-1:0]              right_age,
    input  swm_pkg::swm_flag_t            right_flag,
    input  logic                          seen_in,
    output logic                          seen_out,
    output logic signed [SAMPLE_BITS-1:0] val_out,
    output logic [AGE_W-1:0]              age_out,
    output swm_pkg::swm_flag_t            flag_out
);
    import swm_pkg::*;

    typedef enum logic [1:0] {
        SRC_KEEP,
        SRC_NEW,
        SRC_LEFT,
        SRC_RIGHT
    } src_t;

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [AGE_W-1:0]              age_reg, age_next;
    logic                          valid_me, gt_me, le_me;
    logic                          left_gt, right_le, is_evict;
    src_t                          src;

    // Local status
    assign valid_me = CNT_W'(IDX) < fill;
    assign gt_me    = val_reg > x;
    assign le_me    = valid_me && !gt_me;
    assign left_gt  = left_flag.valid && left_flag.gt;
    assign right_le = right_flag.valid && !right_flag.gt;

    // Freed slot: the oldest entry when full, else the first empty cell
    assign is_evict = ctl.full ? (valid_me && (age_reg == len_m1))
                               : (!valid_me && left_flag.valid);
    assign seen_out = seen_in || is_evict;

    assign val_out        = val_reg;
    assign age_out        = age_reg;
    assign flag_out.valid = valid_me;
    assign flag_out.gt    = gt_me;

    // Pick the source: below the freed slot shift up, above it shift down
    always_comb begin
        if (is_evict) begin
            if (left_gt) begin
                src = SRC_LEFT;
            end else if (right_le) begin
                src = SRC_RIGHT;
            end else begin
                src = SRC_NEW;
            end
        end else if (seen_in) begin
            if (right_le) begin
                src = SRC_RIGHT;
            end else if (le_me) begin
                src = SRC_NEW;
            end else begin
                src = SRC_KEEP;
            end
        end else begin
            if (le_me) begin
                src = SRC_KEEP;
            end else if (!left_gt) begin
                src = SRC_NEW;
            end else begin
                src = SRC_LEFT;
            end
        end
    end

    always_comb begin
        case (src)
            SRC_NEW: begin
                val_next = x;
                age_next = '0;
            end
            SRC_LEFT: begin
                val_next = left_val;
                age_next = left_age + AGE_W'(1);
            end
            SRC_RIGHT: begin
                val_next = right_val;
                age_next = right_age + AGE_W'(1);
            end
            default: begin
                val_next = val_reg;
                age_next = age_reg + AGE_W'(1);
            end
        endcase
    end

    // Advance on every accepted item
    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

FILE: rtl/sliding_window_median_core.sv
// Channel  | Ports                                 | Moves
// ---------+---------------------------------------+----------------------------
// input    | s_valid s_ready s_sample s_restart    | one sample item per accept
// result   | m_valid m_ready m_median              | one median item, when full
// config   | cfg_we cfg_wdata                      | window length, no wait
//
// One item is taken per cycle while s_ready is high; the sorted cell row
// updates in the accept cycle. A median is then pending and enters the output
// register once it is free; it leaves on the m_valid/m_ready handshake.
// Reset, a length write and a restart item empty the window; no reset sweep.
// s_ready drops only while a median is pending and the output register stalls.
module sliding_window_median_core #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_median,
    input  logic                          cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]     cfg_wdata
);
    import swm_pkg::*;

    localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0]              len_cfg_reg;
    logic [CNT_W-1:0]              len_eff, fill_reg, fill_next, fill_eff;
    logic [AGE_W-1:0]              len_m1, mid;
    logic                          full, produce, accept, out_free;
    logic                          pend_reg, m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] median_reg;
    swm_ctl_t                      ctl;

    logic signed [SAMPLE_BITS-1:0] cell_val  [WINDOW_MAX];
    logic [AGE_W-1:0]              cell_age  [WINDOW_MAX];
    swm_flag_t                     cell_flag [WINDOW_MAX];
    logic [WINDOW_MAX:0]           seen;

    // Clamp the requested length into 1..WINDOW_MAX
    always_comb begin
        if (len_cfg_reg == '0) begin
            len_eff = CNT_W'(1);
        end else if (32'(len_cfg_reg) > 32'(WINDOW_MAX)) begin
            len_eff = CNT_W'(WINDOW_MAX);
        end else begin
            len_eff = CNT_W'(len_cfg_reg);
        end
    end

    assign len_m1 = AGE_W'(len_eff - CNT_W'(1));
    assign mid    = AGE_W'((len_eff - CNT_W'(1)) >> 1);

    // Fill tracking: a restart drops the window before this item
    assign fill_eff  = (s_restart || (fill_reg > len_eff)) ? '0 : fill_reg;
    assign full      = (fill_eff == len_eff);
    assign fill_next = full ? len_eff : fill_eff + CNT_W'(1);
    assign produce   = ((CNT_W + 1)'(fill_eff) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(len_eff);

    // Handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !pend_reg || out_free;
    assign accept   = s_valid && s_ready;

    assign ctl.step = accept;
    assign ctl.full = full;

    // Row of sorted cells
    assign seen[0] = 1'b0;
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] lv, rv;
        logic [AGE_W-1:0]              la, ra;
        swm_flag_t                     lf, rf;

        if (i == 0) begin : g_lo
            assign lv = '0;
            assign la = '0;
            assign lf = '{valid: 1'b1, gt: 1'b0};
        end else begin : g_mid_lo
            assign lv = cell_val[i-1];
            assign la = cell_age[i-1];
            assign lf = cell_flag[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_hi
            assign rv = '0;
            assign ra = '0;
            assign rf = '{valid: 1'b0, gt: 1'b0};
        end else begin : g_mid_hi
            assign rv = cell_val[i+1];
            assign ra = cell_age[i+1];
            assign rf = cell_flag[i+1];
        end

        swm_cell #(
            .WINDOW_MAX  (WINDOW_MAX),
            .SAMPLE_BITS (SAMPLE_BITS),
            .IDX         (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .x          (s_sample),
            .len_m1     (len_m1),
            .fill       (fill_eff),
            .left_val   (lv),
            .left_age   (la),
            .left_flag  (lf),
            .right_val  (rv),
            .right_age  (ra),
            .right_flag (rf),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .val_out    (cell_val[i]),
            .age_out    (cell_age[i]),
            .flag_out   (cell_flag[i])
        );
    end

    // Hold the length register, fill count and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= LEN_RESET;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                len_cfg_reg <= cfg_wdata;
                fill_reg    <= '0;
            end else if (accept) begin
                fill_reg <= fill_next;
            end

            if (pend_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (accept) begin
                pend_reg <= produce;
            end else if (out_free) begin
                pend_reg <= 1'b0;
            end
        end
    end

    // Pick the median from the updated row into the output register
    always_ff @(posedge aclk) begin
        if (pend_reg && out_free) begin
            median_reg <= cell_val[mid];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_median = median_reg;

endmodule

FILE: rtl/swm_checker.sv
`include "sliding_window_median_core_macros.svh"

module swm_checker #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_median
);
    import swm_pkg::*;

    // A stalled median holds
    `SWM_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_median))

    // Input back-pressure only comes from a stalled result
    `SWM_ASSERT_SAME(a_stall, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // A new result follows an accepted item through the pending flag
    `SWM_ASSERT_SAME(a_cause, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 2))

endmodule

bind sliding_window_median_core swm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swm_checker (.*);

FILE: tb/tb_sliding_window_median_core.sv
module tb_sliding_window_median_core;

    import swm_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int WM = WINDOW_MAX_DEF;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [SW-1:0] s_sample;
    logic                 s_restart;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [SW-1:0] m_median;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;

    // Idle chances in percent for the sender and the receiver
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;

    // Shadow window: arrival order, sorted order, fill and oldest slot
    logic signed [SW-1:0] shadow_ring [0:WM-1];
    logic signed [SW-1:0] shadow_sorted [0:WM-1];
    int unsigned          shadow_fill;
    int unsigned          shadow_oldest;
    logic [CFG_W-1:0]     shadow_len;

    logic signed [SW-1:0] expected_medians [$];

    sliding_window_median_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_median  (m_median),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Insert v into the first n sorted entries
    function automatic void sorted_place(input int unsigned n, input logic signed [SW-1:0] v);
        int unsigned i;
        i = n;
        while (i > 0 && v < shadow_sorted[i-1]) begin
            shadow_sorted[i] = shadow_sorted[i-1];
            i--;
        end
        shadow_sorted[i] = v;
    endfunction

    // Advance the shadow window by one item and queue the median it yields
    function automatic void predict_median(input logic signed [SW-1:0] x, input logic rs);
        int unsigned          len;
        int unsigned          pos;
        int                   hit;
        logic signed [SW-1:0] old;
        if (shadow_len == 0)
            len = 1;
        else if (shadow_len > WM)
            len = WM;
        else
            len = shadow_len;
        if (rs || shadow_fill > len) begin
            shadow_fill = 0;
            shadow_oldest = 0;
        end
        if (shadow_fill < len) begin
            shadow_ring[shadow_fill] = x;
            sorted_place(shadow_fill, x);
            shadow_fill++;
            if (shadow_fill < len)
                return;
        end else begin
            pos = shadow_oldest % len;
            old = shadow_ring[pos];
            hit = -1;
            for (int i = 0; i < len; i++)
                if (hit < 0 && shadow_sorted[i] == old)
                    hit = i;
            if (hit >= 0) begin
                for (int i = hit; i + 1 < len; i++)
                    shadow_sorted[i] = shadow_sorted[i+1];
                sorted_place(len - 1, x);
            end else begin
                shadow_sorted[len-1] = x;
            end
            shadow_ring[pos] = x;
            shadow_oldest = (pos + 1) % len;
        end
        expected_medians.push_back(shadow_sorted[(len - 1) / 2]);
    endfunction

    // Random back-pressure on the result channel
    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Compare each accepted median with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_medians.size() == 0) begin
                $display("%0t: unexpected median: expected none, actual %0d", $time, m_median);
                fail_count++;
            end else begin
                if (m_median !== expected_medians[0]) begin
                    $display("%0t: median mismatch: expected %0d, actual %0d",
                             $time, expected_medians[0], m_median);
                    fail_count++;
                end
                void'(expected_medians.pop_front());
            end
        end
    end

    // Send one item, holding it until accepted
    task automatic push_sample(input logic signed [SW-1:0] smp, input logic rs);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= smp;
        s_restart <= rs;
        do @(posedge aclk); while (!s_ready);
        predict_median(smp, rs);
    endtask

    // Drop valid and wait until every median has come out
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_medians.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Write the window length once the block is idle
    task automatic write_window_len(input logic [CFG_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_len    = v;
        shadow_fill   = 0;
        shadow_oldest = 0;
    endtask

    // Reset length of three, equal samples and extremes
    task automatic test_default_window();
        push_sample(5, 1'b0);
        push_sample(-7, 1'b0);
        push_sample(5, 1'b0);
        push_sample(5, 1'b0);
        push_sample(32'sh7fffffff, 1'b0);
        push_sample(32'sh80000000, 1'b0);
    endtask

    // Length one passes samples through; zero acts as one
    task automatic test_pass_through();
        write_window_len(7'd1);
        push_sample(32'sh7fffffff, 1'b0);
        push_sample(32'sh80000000, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-1, 1'b0);
        write_window_len(7'd0);
        push_sample(32'sh55555555, 1'b0);
        push_sample(32'shaaaaaaaa, 1'b1);
    endtask

    // Length two gives the smaller of the last pair
    task automatic test_pair_minimum();
        write_window_len(7'd2);
        push_sample(10, 1'b0);
        push_sample(-10, 1'b0);
        push_sample(3, 1'b0);
        push_sample(3, 1'b0);
        push_sample(32'sh80000000, 1'b0);
    endtask

    // Restart while filling and after the window is full
    task automatic test_restart();
        write_window_len(7'd4);
        push_sample(1, 1'b1);
        push_sample(2, 1'b0);
        push_sample(9, 1'b1);
        push_sample(8, 1'b0);
        push_sample(7, 1'b0);
        push_sample(6, 1'b0);
        push_sample(5, 1'b0);
        push_sample(4, 1'b1);
    endtask

    // Random samples at one window length, many of them repeated values
    task automatic feed_random(input int count, input logic [CFG_W-1:0] len_val);
        int                   sel;
        logic signed [SW-1:0] v;
        logic                 rs;
        write_window_len(len_val);
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2: begin
                    v = $urandom_range(0, 6);
                    v = v - 3;
                end
                3: v = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
                4, 5: begin
                    v = $urandom_range(0, 200);
                    v = v - 100;
                end
                default: v = $urandom();
            endcase
            rs = (len_val <= 16) && ($urandom_range(0, 29) == 0);
            push_sample(v, rs);
        end
    endtask

    // Random traffic over several lengths, one idle pattern each
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int phase);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        case (phase)
            0: begin
                feed_random(40, 7'd3);
                feed_random(80, 7'd127);
                feed_random(40, 7'($urandom_range(1, 20)));
            end
            1: begin
                feed_random(75, 7'd64);
                feed_random(40, 7'd5);
                feed_random(40, 7'($urandom_range(0, 12)));
            end
            default: begin
                feed_random(40, 7'd4);
                feed_random(20, 7'd1);
                feed_random(50, 7'($urandom_range(1, 12)));
            end
        endcase
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_sample  = '0;
        s_restart = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        shadow_len    = LEN_RESET;
        shadow_fill   = 0;
        shadow_oldest = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_window();
        test_pass_through();
        test_pair_minimum();
        test_restart();
        test_random_traffic(21, 54, 0);
        test_random_traffic(54, 21, 1);
        test_random_traffic(0, 0, 2);
        settle();

        if (fail_count == 0)
            $display("** sliding_window_median_core: PASSED **");
        else
            $display("** sliding_window_median_core: FAILED **");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5000000;
        $display("** sliding_window_median_core: FAILED **");
        $finish;
    end

endmodule
